@@ rtl/core/apc_pkg.sv @@
// Package for the AXI phase protocol checker: field types, phase and
// operation codes, violation bit positions and storage sizes. No dependencies.
package apc_pkg;

    localparam int ID_COUNT   = 16;
    localparam int ID_BITS    = $clog2(ID_COUNT);
    localparam int FIFO_DEPTH = 8;
    localparam int SLOT_BITS  = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);
    localparam int TAG_BITS   = 8;
    localparam int TAG_ADDR_BITS = 1 + ID_BITS + SLOT_BITS;
    localparam int TAG_ENTRIES   = 2 * ID_COUNT * FIFO_DEPTH;
    localparam int VIOL_BITS  = 9;
    localparam logic [7:0] BUS_BYTES_RESET = 8'd8;
    localparam logic [7:0] QOS_MAX = 8'd15;
    localparam logic [3:0] CACHE_ALLOC_MASK = 4'hC;
    localparam logic [3:0] CACHE_MODIFY_MASK = 4'h2;

    // violation bit positions
    localparam int V_IGN   = 0;
    localparam int V_PHASE = 1;
    localparam int V_ID    = 2;
    localparam int V_BEATS = 3;
    localparam int V_ORDER = 4;
    localparam int V_LEN   = 5;
    localparam int V_QOS   = 6;
    localparam int V_CACHE = 7;
    localparam int V_FIFO  = 8;

    localparam logic [1:0] OP_FWD_CALL = 2'd0;
    localparam logic [1:0] OP_FWD_RET  = 2'd1;
    localparam logic [1:0] OP_BWD_CALL = 2'd2;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_IGN   = 2'd2;
    localparam logic [1:0] CMD_OTHER = 2'd3;

    localparam logic [3:0] PC_BEGIN_REQ   = 4'd0;
    localparam logic [3:0] PC_END_REQ     = 4'd1;
    localparam logic [3:0] PC_BEGIN_RESP  = 4'd2;
    localparam logic [3:0] PC_END_RESP    = 4'd3;
    localparam logic [3:0] PC_BEGIN_PREQ  = 4'd4;
    localparam logic [3:0] PC_END_PREQ    = 4'd5;
    localparam logic [3:0] PC_BEGIN_PRESP = 4'd6;
    localparam logic [3:0] PC_END_PRESP   = 4'd7;

    localparam logic [1:0] EXT_AXI4 = 2'd1;
    localparam logic [1:0] EXT_ACE  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE, PH_BREQ, PH_BPREQ, PH_BRESP, PH_BPRESP
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE, S_EXEC, S_CHK
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  command;
        logic [3:0]  phase_code;
        logic [3:0]  trans_id;
        logic [8:0]  burst_beats;
        logic [7:0]  beat_bytes;
        logic [6:0]  address_low;
        logic [15:0] data_bytes;
        logic [7:0]  handle;
        logic [1:0]  ext_kind;
        logic [3:0]  cache_bits;
        logic [7:0]  qos_value;
    } evt_t;

endpackage

@@ rtl/core/apc_evt_if.sv @@
// Event channel of the AXI phase protocol checker: valid/ready with one
// phase event as payload. Depends on apc_pkg.
interface apc_evt_if;
    logic           valid;
    logic           ready;
    apc_pkg::evt_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/apc_res_if.sv @@
// Result channel of the AXI phase protocol checker: valid/ready with the
// violation mask as payload. Depends on apc_pkg.
interface apc_res_if;
    logic                            valid;
    logic                            ready;
    logic [apc_pkg::VIOL_BITS-1:0]   violations;

    modport source (output valid, output violations, input ready);
    modport sink   (input valid, input violations, output ready);
endinterface

@@ rtl/core/axi_phase_protocol_checker.sv @@
// Top level of the AXI phase protocol checker: phase tracking, per-ID tag
// FIFOs in a synchronous memory, result register. Depends on apc_pkg,
// apc_evt_if and apc_res_if.

// Each phase event passes through accept, an execute step that updates the
// phase, owner, beat and FIFO pointer state and issues at most one access to
// the tag memory, and a check step that compares any tag read back from the
// head of the per-ID FIFO and loads the result register, waiting while that
// register still holds a result not yet taken. A new event is taken once the
// previous one has reached the result register. No clearing pass is needed
// after reset: FIFO pointers reset to empty and only written entries are read.
module axi_phase_protocol_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    apc_evt_if.sink           evt,
    apc_res_if.source         res
);
    import apc_pkg::*;

    state_t state_reg, state_next;
    evt_t   e_reg;
    logic [7:0] bus_bytes_reg;

    phase_t req_phase_reg [3];
    phase_t rsp_phase_reg [3];
    logic [1:0] req_own_valid_reg;
    logic [1:0] rsp_own_valid_reg;
    logic [ID_BITS-1:0] req_owner_reg [2];
    logic [ID_BITS-1:0] rsp_owner_reg [2];
    logic [8:0] wbc_reg;
    logic [8:0] rbc_reg [ID_COUNT];
    logic [SLOT_BITS-1:0] head_reg [2][ID_COUNT];
    logic [CNT_BITS-1:0]  cnt_reg  [2][ID_COUNT];

    logic [TAG_BITS-1:0] tag_mem [TAG_ENTRIES];
    logic [TAG_BITS-1:0] tag_rdata;

    logic [VIOL_BITS-1:0] viol_reg, viol_next;
    logic chk_reg, chk_next;
    logic [TAG_BITS-1:0] chk_tag_reg;
    logic out_valid_reg;
    logic [VIOL_BITS-1:0] out_data_reg;

    // execute-cycle combinational results
    logic [1:0] cmd;
    logic [ID_BITS-1:0] k;
    logic [TAG_BITS-1:0] tag;
    phase_t rp, rs, cr, cs;
    logic dir;
    logic push_en, pop_en, front_en, mem_wr, mem_rd;
    logic [1:0] rov_next, sov_next;
    logic [ID_BITS-1:0] rown_next, sown_next;
    logic [8:0] wbc_next, rbc_next;
    logic [SLOT_BITS-1:0] fhead;
    logic [CNT_BITS-1:0]  fcnt;
    logic [7:0]  mask, off;
    logic [16:0] total, dsum;
    logic props;
    logic exec_en, chk_done, in_ready;

    assign exec_en  = (state_reg == S_EXEC);
    assign chk_done = (state_reg == S_CHK) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (evt.valid) state_next = S_EXEC;
            S_EXEC: state_next = S_CHK;
            S_CHK:  if (!out_valid_reg || res.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            default: in_ready = 1'b0;
        endcase
    end

    assign evt.ready      = in_ready;
    assign res.valid      = out_valid_reg;
    assign res.violations = out_data_reg;

    assign cmd = (e_reg.command == CMD_OTHER) ? CMD_IGN : e_reg.command;
    assign k   = e_reg.trans_id[ID_BITS-1:0];
    assign tag = e_reg.handle[TAG_BITS-1:0];
    assign dir = cmd[0];
    assign fhead = head_reg[dir][k];
    assign fcnt  = cnt_reg[dir][k];

    // request property checks
    assign mask  = bus_bytes_reg - 8'd1;
    assign off   = {1'b0, e_reg.address_low} & mask;
    assign total = {9'd0, e_reg.beat_bytes} * {8'd0, e_reg.burst_beats};
    assign dsum  = {1'b0, e_reg.data_bytes} + {9'd0, off};

    always_comb
    begin
        viol_next = '0;
        rp = req_phase_reg[cmd];
        rs = rsp_phase_reg[cmd];
        if ((e_reg.operation == OP_FWD_CALL || e_reg.operation == OP_BWD_CALL)
            && cmd == CMD_IGN)
            viol_next[V_IGN] = 1'b1;
        else if (e_reg.operation == OP_FWD_RET && rp == PH_BREQ &&
                 (e_reg.phase_code == PC_BEGIN_RESP ||
                  e_reg.phase_code == PC_BEGIN_PRESP))
            rp = PH_IDLE;
        cr = rp;
        cs = rs;
        case (e_reg.phase_code)
            PC_BEGIN_REQ:   begin viol_next[V_PHASE] = (cr != PH_IDLE);   cr = PH_BREQ;   end
            PC_BEGIN_PREQ:  begin viol_next[V_PHASE] = (cr != PH_IDLE);   cr = PH_BPREQ;  end
            PC_END_PREQ:    begin viol_next[V_PHASE] = (cr != PH_BPREQ);  cr = PH_IDLE;   end
            PC_END_REQ:     begin viol_next[V_PHASE] = (cr != PH_BREQ);   cr = PH_IDLE;   end
            PC_BEGIN_RESP:  begin viol_next[V_PHASE] = (cs != PH_IDLE);   cs = PH_BRESP;  end
            PC_BEGIN_PRESP: begin viol_next[V_PHASE] = (cs != PH_IDLE);   cs = PH_BPRESP; end
            PC_END_RESP:    begin viol_next[V_PHASE] = (cs != PH_BRESP);  cs = PH_IDLE;   end
            PC_END_PRESP:   begin viol_next[V_PHASE] = (cs != PH_BPRESP); cs = PH_IDLE;   end
            default:        viol_next[V_PHASE] = 1'b1;
        endcase

        props = 1'b0;
        push_en = 1'b0;
        pop_en = 1'b0;
        front_en = 1'b0;
        rov_next = req_own_valid_reg;
        sov_next = rsp_own_valid_reg;
        rown_next = req_owner_reg[dir];
        sown_next = rsp_owner_reg[dir];
        wbc_next = wbc_reg;
        rbc_next = rbc_reg[k];

        if (rp != cr)
        begin
            if (cmd == CMD_WRITE)
            begin
                if (cr == PH_IDLE)
                    rov_next[1] = 1'b0;
                else
                begin
                    if (!req_own_valid_reg[1])
                    begin
                        rov_next[1] = 1'b1;
                        rown_next = k;
                        wbc_next = wbc_reg + 9'd1;
                    end
                    else if (req_owner_reg[1] != k)
                        viol_next[V_ID] = 1'b1;
                    if (cr == PH_BREQ)
                    begin
                        if (wbc_next != e_reg.burst_beats) viol_next[V_BEATS] = 1'b1;
                        wbc_next = '0;
                        push_en = 1'b1;
                        props = 1'b1;
                    end
                end
            end
            else if (cmd == CMD_READ)
            begin
                if (cr == PH_IDLE)
                    rov_next[0] = 1'b0;
                else if (cr == PH_BREQ)
                begin
                    if (!req_own_valid_reg[0])
                    begin
                        rov_next[0] = 1'b1;
                        rown_next = k;
                        push_en = 1'b1;
                    end
                    else if (req_owner_reg[0] != k)
                        viol_next[V_ID] = 1'b1;
                    props = 1'b1;
                end
                else
                    viol_next[V_ID] = 1'b1;
            end
        end

        if (rs != cs)
        begin
            if (cmd == CMD_WRITE)
            begin
                if (cs == PH_IDLE)
                    sov_next[1] = 1'b0;
                else if (cs == PH_BRESP)
                begin
                    if (!rsp_own_valid_reg[1])
                    begin
                        sov_next[1] = 1'b1;
                        sown_next = k;
                        front_en = 1'b1;
                    end
                    else if (rsp_owner_reg[1] != k)
                        viol_next[V_ID] = 1'b1;
                    pop_en = 1'b1;
                end
                else
                    viol_next[V_ID] = 1'b1;
            end
            else if (cmd == CMD_READ)
            begin
                if (cs == PH_IDLE)
                    sov_next[0] = 1'b0;
                else
                begin
                    if (!rsp_own_valid_reg[0])
                    begin
                        sov_next[0] = 1'b1;
                        sown_next = k;
                        front_en = 1'b1;
                        rbc_next = rbc_reg[k] + 9'd1;
                    end
                    else if (rsp_owner_reg[0] != k)
                        viol_next[V_ID] = 1'b1;
                    if (cs == PH_BRESP)
                    begin
                        if (rbc_next != e_reg.burst_beats) viol_next[V_BEATS] = 1'b1;
                        pop_en = 1'b1;
                        rbc_next = '0;
                    end
                end
            end
        end

        if (props)
        begin
            if (off == 8'd0)
            begin
                if ({1'b0, e_reg.data_bytes} != total) viol_next[V_LEN] = 1'b1;
            end
            else if (dsum > total)
                viol_next[V_LEN] = 1'b1;
            if (e_reg.ext_kind == EXT_AXI4 || e_reg.ext_kind == EXT_ACE)
            begin
                if ((e_reg.cache_bits & CACHE_ALLOC_MASK) != 4'd0 &&
                    (e_reg.cache_bits & CACHE_MODIFY_MASK) == 4'd0)
                    viol_next[V_CACHE] = 1'b1;
                if (e_reg.ext_kind == EXT_AXI4 && e_reg.qos_value > QOS_MAX)
                    viol_next[V_QOS] = 1'b1;
            end
        end

        // empty or full FIFO flags misuse and blocks the access
        mem_wr = 1'b0;
        mem_rd = 1'b0;
        if (push_en)
        begin
            if (fcnt >= CNT_BITS'(FIFO_DEPTH)) viol_next[V_FIFO] = 1'b1;
            else mem_wr = 1'b1;
        end
        if (front_en)
        begin
            if (fcnt == '0) viol_next[V_FIFO] = 1'b1;
            else mem_rd = 1'b1;
        end
        if (pop_en && fcnt == '0) viol_next[V_FIFO] = 1'b1;
        chk_next = mem_rd;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr && exec_en)
            tag_mem[{dir, k, SLOT_BITS'(fhead + fcnt[SLOT_BITS-1:0])}] <= tag;
        if (mem_rd && exec_en)
            tag_rdata <= tag_mem[{dir, k, fhead}];
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && in_ready)
            e_reg <= evt.payload;
        if (exec_en)
        begin
            viol_reg    <= viol_next;
            chk_tag_reg <= tag;
        end
        if (chk_done)
            out_data_reg <= viol_reg | (VIOL_BITS'(chk_reg && tag_rdata != chk_tag_reg) << V_ORDER);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            bus_bytes_reg     <= BUS_BYTES_RESET;
            req_phase_reg     <= '{default: PH_IDLE};
            rsp_phase_reg     <= '{default: PH_IDLE};
            req_own_valid_reg <= '0;
            rsp_own_valid_reg <= '0;
            req_owner_reg     <= '{default: '0};
            rsp_owner_reg     <= '{default: '0};
            wbc_reg           <= '0;
            rbc_reg           <= '{default: '0};
            head_reg          <= '{default: '{default: '0}};
            cnt_reg           <= '{default: '{default: '0}};
            chk_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                bus_bytes_reg <= cfg_wr_data;
            if (exec_en)
            begin
                req_phase_reg[cmd] <= cr;
                rsp_phase_reg[cmd] <= cs;
                req_own_valid_reg  <= rov_next;
                rsp_own_valid_reg  <= sov_next;
                if (cmd != CMD_IGN)
                begin
                    req_owner_reg[dir] <= rown_next;
                    rsp_owner_reg[dir] <= sown_next;
                end
                wbc_reg    <= wbc_next;
                rbc_reg[k] <= rbc_next;
                chk_reg    <= chk_next;
                if (pop_en && fcnt != '0)
                begin
                    head_reg[dir][k] <= SLOT_BITS'(fhead + SLOT_BITS'(1));
                    cnt_reg[dir][k]  <= fcnt - CNT_BITS'(1);
                end
                else if (mem_wr)
                    cnt_reg[dir][k] <= fcnt + CNT_BITS'(1);
            end
            if (chk_done)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule
